// ----- sv/mlpf_pkg.sv -----
package mlpf_pkg;

  // Queue geometry.
  localparam int NUM_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 16;
  localparam int MEM_DEPTH   = NUM_LEVELS * LEVEL_DEPTH;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SLOT_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // Field widths on the stream ports.
  localparam int CMD_W      = 2;
  localparam int LEVEL_FW   = 3;
  localparam int ID_W       = 8;
  localparam int ST_W       = 2;
  localparam int RC_W       = 8;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;
  localparam int M_PAD_W    = M_TDATA_W - ID_W - LEVEL_FW - RC_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RM  = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic enq_do;
    logic deq_do;
    logic deq_rd;
    logic rm_step;
    logic load_out;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic found;
    logic scan_done;
    logic scan_last;
  } stat_t;

endpackage

// ----- sv/mlpf_dp.sv -----
module mlpf_dp import mlpf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl,
  input  logic [LEVEL_FW-1:0] in_level,
  input  logic [ID_W-1:0]     in_job_id,
  output stat_t               stat,
  output logic [ST_W-1:0]     out_status,
  output logic [ID_W-1:0]     out_job_id,
  output logic [LEVEL_FW-1:0] out_level,
  output logic [RC_W-1:0]     removed_count
);

  localparam int SUM_W = CNT_W + 1;

  // Adds an offset to a head slot, wrapping once around the level.
  function automatic logic [SLOT_W-1:0] wrap_off(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(LEVEL_DEPTH)) begin
      s = s - SUM_W'(LEVEL_DEPTH);
    end
    return SLOT_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0]  lv,
                                                  input logic [SLOT_W-1:0] off);
    return ADDR_W'(lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(off);
  endfunction

  logic [ID_W-1:0]     mem [MEM_DEPTH];
  logic [ID_W-1:0]     rdata;

  logic [LEVEL_FW-1:0] lvl_r;
  logic [ID_W-1:0]     id_r;
  logic [NUM_LEVELS-1:0] bitmap;
  logic [SLOT_W-1:0]   head  [NUM_LEVELS];
  logic [CNT_W-1:0]    count [NUM_LEVELS];
  logic [LVL_W-1:0]    scan_lvl;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    kept;
  logic                pend;

  logic [ST_W-1:0]     res_status;
  logic [ID_W-1:0]     res_job;
  logic [LEVEL_FW-1:0] res_level;
  logic [RC_W-1:0]     res_count;

  logic [LVL_W-1:0]    pe_lvl;
  logic [LVL_W-1:0]    sel;
  logic [SLOT_W-1:0]   head_s;
  logic [CNT_W-1:0]    count_s;
  logic                enq_ok;
  logic                deq_ok;
  logic                scan_done;
  logic                rd_go;
  logic                keep_wr;
  logic                we;
  logic                re;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [ID_W-1:0]     wdata;

  // Lowest-numbered non-empty level.
  always_comb begin
    pe_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (bitmap[i]) begin
        pe_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    if (ctl.enq_do) begin
      sel = LVL_W'(lvl_r);
    end else if (ctl.deq_do) begin
      sel = pe_lvl;
    end else begin
      sel = scan_lvl;
    end
  end

  assign head_s    = head[sel];
  assign count_s   = count[sel];
  assign enq_ok    = (32'(lvl_r) < NUM_LEVELS) && (count_s < CNT_W'(LEVEL_DEPTH));
  assign deq_ok    = (|bitmap) && (count_s != '0);
  assign scan_done = !pend && (rd_idx == count_s);
  assign rd_go     = ctl.rm_step && (rd_idx < count_s);
  assign keep_wr   = ctl.rm_step && pend && (rdata != id_r);

  assign stat.found     = deq_ok;
  assign stat.scan_done = scan_done;
  assign stat.scan_last = (scan_lvl == LVL_W'(NUM_LEVELS - 1));

  assign we    = (ctl.enq_do && enq_ok) || keep_wr;
  assign waddr = ctl.enq_do ? slot_addr(sel, wrap_off(head_s, count_s))
                            : slot_addr(sel, wrap_off(head_s, kept));
  assign wdata = ctl.enq_do ? id_r : rdata;
  assign re    = (ctl.deq_do && deq_ok) || rd_go;
  assign raddr = ctl.deq_do ? slot_addr(sel, head_s)
                            : slot_addr(sel, wrap_off(head_s, rd_idx));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap   <= '0;
      scan_lvl <= '0;
      rd_idx   <= '0;
      kept     <= '0;
      pend     <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (ctl.accept) begin
        scan_lvl <= '0;
        rd_idx   <= '0;
        kept     <= '0;
        pend     <= 1'b0;
      end
      if (ctl.enq_do && enq_ok) begin
        count[sel]  <= count_s + CNT_W'(1);
        bitmap[sel] <= 1'b1;
      end
      if (ctl.deq_do && deq_ok) begin
        head[sel]  <= wrap_off(head_s, CNT_W'(1));
        count[sel] <= count_s - CNT_W'(1);
        if (count_s == CNT_W'(1)) begin
          bitmap[sel] <= 1'b0;
        end
      end
      if (ctl.rm_step) begin
        if (scan_done) begin
          count[sel] <= kept;
          if (kept == '0) begin
            bitmap[sel] <= 1'b0;
          end
          scan_lvl <= scan_lvl + LVL_W'(1);
          rd_idx   <= '0;
          kept     <= '0;
        end else begin
          pend <= rd_go;
          if (rd_go) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (keep_wr) begin
            kept <= kept + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      lvl_r      <= in_level;
      id_r       <= in_job_id;
      res_status <= ST_OK;
      res_job    <= '0;
      res_level  <= '0;
      res_count  <= '0;
    end
    if (ctl.enq_do && !enq_ok) begin
      res_status <= ST_FULL;
    end
    if (ctl.deq_do) begin
      if (deq_ok) begin
        res_level <= LEVEL_FW'(sel);
      end else begin
        res_status <= ST_EMPTY;
      end
    end
    if (ctl.deq_rd) begin
      res_job <= rdata;
    end
    if (ctl.rm_step && pend && (rdata == id_r) && (res_count != '1)) begin
      res_count <= res_count + RC_W'(1);
    end
    if (ctl.load_out) begin
      out_status    <= res_status;
      out_job_id    <= res_job;
      out_level     <= res_level;
      removed_count <= res_count;
    end
  end

endmodule

// ----- sv/mlpf_ctrl.sv -----
module mlpf_ctrl import mlpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [CMD_W-1:0] in_command,
  output logic             m_valid,
  input  logic             m_ready,
  input  stat_t            stat,
  output ctl_t             ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ENQ    = 3'd1;
  localparam logic [2:0] S_DEQ    = 3'd2;
  localparam logic [2:0] S_DEQ_RD = 3'd3;
  localparam logic [2:0] S_RM     = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !m_valid || m_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    s_ready    = (state == S_IDLE) || ((state == S_RESP) && out_free);
    ctl.accept = s_valid && s_ready;

    unique case (state)
      S_IDLE: begin
      end
      S_ENQ: begin
        ctl.enq_do = 1'b1;
        state_next = S_RESP;
      end
      S_DEQ: begin
        ctl.deq_do = 1'b1;
        state_next = stat.found ? S_DEQ_RD : S_RESP;
      end
      S_DEQ_RD: begin
        ctl.deq_rd = 1'b1;
        state_next = S_RESP;
      end
      S_RM: begin
        ctl.rm_step = 1'b1;
        if (stat.scan_done && stat.scan_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A new word starts its command right away; unused codes answer zeros.
    if (ctl.accept) begin
      unique case (in_command)
        CMD_ENQ: state_next = S_ENQ;
        CMD_DEQ: state_next = S_DEQ;
        CMD_RM:  state_next = S_RM;
        default: state_next = S_RESP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/multi_level_priority_fifo_unit.sv -----
// Multi-level priority FIFO: one FIFO of job ids per priority level and a
// bitmap of the levels that hold entries. Level 0 is served first.
// Command words arrive on the s_axis channel: tuser carries the command
// (enqueue, dequeue, remove all entries of a job id), tdata the level and the
// job id. Every command word yields exactly one result word on m_axis: tuser
// carries the status (ok, queue empty, level full), tdata the dequeued job id,
// its level and the number of entries a remove took out.
// An enqueue reaches the result register through state S_ENQ, a dequeue
// through S_DEQ and S_DEQ_RD, since the job id comes out of the registered
// read port of the entry memory. A remove walks every level through the
// single-port-read entry memory, one entry per cycle. Commands run one at a
// time; a new command word is taken only in the idle or the result state.
// A new command word is accepted while the previous result still sits in
// the output register; if the receiver stalls, the finished result of the
// following command waits inside until the output register frees up.
// Synchronous reset empties every level and drops any pending result; the
// entry memory itself is not cleared, which needs no clearing pass because
// only entries inside a level's live window are ever read.
module multi_level_priority_fifo_unit import mlpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: level[2:0], job_id[10:3], zero fill[15:11].
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [CMD_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: out_job_id[7:0], out_level[10:8], removed_count[18:11],
  // zero fill[23:19].
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [ST_W-1:0]      m_axis_tuser
);

  ctl_t                ctl;
  stat_t               stat;
  logic [ID_W-1:0]     out_job_id;
  logic [LEVEL_FW-1:0] out_level;
  logic [RC_W-1:0]     removed_count;

  // Sequencer: accepts command words, steps each command and loads results.
  mlpf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .in_command (s_axis_tuser),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  // Entry memory, per-level head and count, bitmap and result registers.
  mlpf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .in_level      (s_axis_tdata[LEVEL_FW-1:0]),
    .in_job_id     (s_axis_tdata[LEVEL_FW+ID_W-1:LEVEL_FW]),
    .stat          (stat),
    .out_status    (m_axis_tuser),
    .out_job_id    (out_job_id),
    .out_level     (out_level),
    .removed_count (removed_count)
  );

  assign m_axis_tdata = {{M_PAD_W{1'b0}}, removed_count, out_level, out_job_id};

endmodule

// ----- sv/mlpf_chk.sv -----
module mlpf_chk import mlpf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [ST_W-1:0]      m_axis_tuser
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word present right after reset");

  // A stalled result word holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // An empty or full answer carries no job, level or count.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("failed command returned nonzero data");

  // A remove count never comes together with a dequeued job.
  a_rm_no_job: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[18:11] != '0) |->
      (m_axis_tdata[10:0] == '0))
    else $error("remove result mixed with dequeue data");

endmodule

bind multi_level_priority_fifo_unit mlpf_chk u_chk (.*);

// ----- verif/multi_level_priority_fifo_unit_tb.sv -----
`timescale 1ns / 100ps

module multi_level_priority_fifo_unit_tb;
  import mlpf_pkg::*;

  // The port has no name for the spare command code; it must answer all zeros.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam int RANDOM_WORDS = 1175;
  localparam int SEG_LEN      = 60;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 700000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [LEVEL_FW-1:0] lvl;
    logic [ID_W-1:0]     job;
    int unsigned         gap;
    bit                  drain;
  } cmd_word_t;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [ID_W-1:0]     job;
    logic [LEVEL_FW-1:0] lvl;
    logic [RC_W-1:0]     removed;
  } answer_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]      m_axis_tuser;

  multi_level_priority_fifo_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Command words waiting to be sent, and answers waiting to come back.
  cmd_word_t cmd_backlog[$];
  answer_t   pending_answers[$];

  // Shadow of the queue contents: each level kept compacted, oldest entry first.
  logic [ID_W-1:0] shadow_mem[NUM_LEVELS][LEVEL_DEPTH];
  int              shadow_cnt[NUM_LEVELS];

  int unsigned n_accepted = 0;
  int unsigned n_answers = 0;
  int unsigned n_mismatch = 0;
  int unsigned cycle_count = 0;
  bit          hold_rx = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    for (int l = 0; l < NUM_LEVELS; l++) shadow_cnt[l] = 0;
  end

  // Applies one command to the shadow queues and returns the answer it must give.
  function automatic answer_t prio_model_apply(input cmd_word_t w);
    answer_t a;
    int      l;
    int      kept;
    int      taken;
    a = '0;
    case (w.cmd)
      CMD_ENQ: begin
        if (w.lvl >= NUM_LEVELS || shadow_cnt[w.lvl] >= LEVEL_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          shadow_mem[w.lvl][shadow_cnt[w.lvl]] = w.job;
          shadow_cnt[w.lvl]++;
        end
      end
      CMD_DEQ: begin
        l = 0;
        while (l < NUM_LEVELS && shadow_cnt[l] == 0) l++;
        if (l == NUM_LEVELS) begin
          a.status = ST_EMPTY;
        end else begin
          a.job = shadow_mem[l][0];
          a.lvl = LEVEL_FW'(l);
          for (int i = 1; i < shadow_cnt[l]; i++) shadow_mem[l][i-1] = shadow_mem[l][i];
          shadow_cnt[l]--;
        end
      end
      CMD_RM: begin
        taken = 0;
        for (l = 0; l < NUM_LEVELS; l++) begin
          kept = 0;
          for (int i = 0; i < shadow_cnt[l]; i++) begin
            if (shadow_mem[l][i] != w.job) begin
              shadow_mem[l][kept] = shadow_mem[l][i];
              kept++;
            end
          end
          taken += shadow_cnt[l] - kept;
          shadow_cnt[l] = kept;
        end
        a.removed = (taken > 255) ? RC_W'(255) : RC_W'(taken);
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic flag_mismatch(input string what, input answer_t want, input answer_t got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("ERROR %0d %s: exp st=%0d job=%02h lvl=%0d rm=%0d got st=%0d job=%02h lvl=%0d rm=%0d",
               n_answers, what, want.status, want.job, want.lvl, want.removed,
               got.status, got.job, got.lvl, got.removed);
  endtask

  task automatic add_word(input logic [CMD_W-1:0] cmd, input logic [LEVEL_FW-1:0] lvl,
                          input logic [ID_W-1:0] job, input bit drain);
    cmd_word_t   w;
    int unsigned idx;
    idx = cmd_backlog.size();
    w.cmd   = cmd;
    w.lvl   = lvl;
    w.job   = job;
    w.drain = drain;
    // Back-to-back words around the receiver hold-off so the block backs up,
    // plus regular stretches with no gaps at all.
    if (idx + 10 >= HOLD_AT && idx <= HOLD_AT + 60) w.gap = 0;
    else if ((idx / 90) % 4 == 1) w.gap = 0;
    else w.gap = $urandom_range(0, 9);
    cmd_backlog.push_back(w);
  endtask

  // Sender: offers the oldest waiting word after its gap. A word marked drain
  // is held back until every outstanding answer has been collected.
  always @(posedge clk) begin : sender
    int unsigned wait_left;
    bit          armed;
    logic        valid_n;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      wait_left = 0;
      armed = 1'b0;
    end else begin
      valid_n = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_answers.push_back(prio_model_apply(cmd_backlog[0]));
        cmd_backlog.pop_front();
        n_accepted <= n_accepted + 1;
        valid_n = 1'b0;
        armed = 1'b0;
      end
      if (!valid_n && cmd_backlog.size() > 0) begin
        if (!armed) begin
          wait_left = cmd_backlog[0].gap;
          armed = 1'b1;
        end
        if (wait_left > 0) begin
          wait_left--;
        end else if (!cmd_backlog[0].drain || pending_answers.size() == 0) begin
          valid_n = 1'b1;
          s_axis_tdata <= {{(S_TDATA_W-LEVEL_FW-ID_W){1'b0}}, cmd_backlog[0].job,
                           cmd_backlog[0].lvl};
          s_axis_tuser <= cmd_backlog[0].cmd;
        end
      end
      s_axis_tvalid <= valid_n;
    end
  end

  // Receiver: checks each answer word against the oldest expectation, then
  // stalls for a random number of cycles except during stall-free stretches.
  always @(posedge clk) begin : receiver
    int unsigned stall_left;
    answer_t     got;
    answer_t     want;
    logic        ready_n;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tuser;
        got.job     = m_axis_tdata[7:0];
        got.lvl     = m_axis_tdata[10:8];
        got.removed = m_axis_tdata[18:11];
        if (pending_answers.size() == 0) begin
          flag_mismatch("unexpected", '0, got);
        end else begin
          want = pending_answers.pop_front();
          if (got.status != want.status || got.job != want.job ||
              got.lvl != want.lvl || got.removed != want.removed)
            flag_mismatch("mismatch", want, got);
        end
        n_answers++;
        stall_left = ((n_answers / 100) % 4 == 3) ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_n = 1'b0;
      end else begin
        ready_n = 1'b1;
      end
      if (hold_rx) ready_n = 1'b0;
      m_axis_tready <= ready_n;
    end
  end

  // One long receiver hold-off, started once enough words have gone in, so the
  // output register and the internal result both fill and s_axis_tready drops.
  always @(posedge clk) begin : rx_hold
    if (rst) begin
      hold_rx <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted == HOLD_AT) begin
      hold_rx <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      hold_rx <= (hold_left > 1);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0]     id_pool[6];
    logic [LEVEL_FW-1:0] fill_a;
    logic [LEVEL_FW-1:0] fill_b;
    logic [CMD_W-1:0]    cmd;
    logic [LEVEL_FW-1:0] lvl;
    logic [ID_W-1:0]     job;
    int unsigned         profile;
    int unsigned         pick;
    int unsigned         enq_pct;
    int unsigned         deq_pct;
    int unsigned         rm_pct;
    bit                  pooled;
    bit                  drain_next;

    // Directed opening: empty dequeue, remove with no match, the spare code,
    // the level and id extremes, one level filled past its depth, and a
    // remove that takes half of a full level while keeping the order.
    add_word(CMD_DEQ, 3'd0, 8'h00, 1'b0);
    add_word(CMD_RM,  3'd0, 8'hAA, 1'b0);
    add_word(CMD_NOP, 3'd7, 8'hFF, 1'b0);
    add_word(CMD_ENQ, 3'd7, 8'hFF, 1'b0);
    add_word(CMD_ENQ, 3'd0, 8'h00, 1'b0);
    for (int i = 0; i < LEVEL_DEPTH; i++)
      add_word(CMD_ENQ, 3'd2, (i % 2 == 0) ? 8'h5A : 8'hA5, 1'b0);
    add_word(CMD_ENQ, 3'd2, 8'h11, 1'b0);
    add_word(CMD_DEQ, 3'd5, 8'h3C, 1'b0);
    add_word(CMD_RM,  3'd2, 8'h5A, 1'b0);
    add_word(CMD_DEQ, 3'd0, 8'h00, 1'b0);

    // Random part in segments with their own command mix. Fill segments aim
    // at two levels so they reach full; a small id pool makes removes hit.
    drain_next = 1'b1;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % SEG_LEN == 0) begin
        profile = $urandom_range(0, 2);
        pooled  = ($urandom_range(0, 9) < 7);
        foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 255));
        fill_a = LEVEL_FW'($urandom_range(0, 7));
        fill_b = LEVEL_FW'($urandom_range(0, 7));
        if (k > 0) drain_next = ($urandom_range(0, 3) == 0);
      end
      case (profile)
        0: begin enq_pct = 75; deq_pct = 15; rm_pct = 7; end
        1: begin enq_pct = 25; deq_pct = 60; rm_pct = 12; end
        default: begin enq_pct = 45; deq_pct = 35; rm_pct = 15; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) cmd = CMD_ENQ;
      else if (pick < enq_pct + deq_pct) cmd = CMD_DEQ;
      else if (pick < enq_pct + deq_pct + rm_pct) cmd = CMD_RM;
      else cmd = CMD_NOP;
      if (profile == 0 && $urandom_range(0, 9) < 8)
        lvl = $urandom_range(0, 1) ? fill_a : fill_b;
      else
        lvl = LEVEL_FW'($urandom_range(0, 7));
      if (pooled || (cmd == CMD_RM && $urandom_range(0, 9) < 8))
        job = id_pool[$urandom_range(0, 5)];
      else
        job = ID_W'($urandom_range(0, 255));
      add_word(cmd, lvl, job, drain_next);
      drain_next = 1'b0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || s_axis_tvalid || pending_answers.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (n_mismatch == 0 && pending_answers.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
